>>> design/assert_macros.svh
// assertion helpers shared by the rtl files
// each expects signals named clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when pre holds, post must hold on the same edge
`define CHK_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

>>> design/srws_pkg.sv
// ----------------------------------------------------------------------------
// srws_pkg
// Types and constants shared by the sample ring window statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srws_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DEPTH       = 1024;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int WIN_BITS    = 11;
  localparam int OUT_BITS    = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS + 1;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS + ADDR_BITS;
  localparam int D_BITS      = 2 * SAMPLE_BITS + 2 * ADDR_BITS + 2;
  localparam int ROOT_BITS   = D_BITS / 2;
  localparam int DIV_BITS    = (SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS;
  localparam int DIV_STEP_BITS = $clog2(DIV_BITS + 1);

  localparam int FQ_DEPTH    = 4;
  localparam int FQ_PTR_BITS = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_BITS = FQ_PTR_BITS + 1;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e                            op;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic        [WIN_BITS-1:0]     win;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_DIFF,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DP_RECENT,
    DP_ALL,
    DP_DEV
  } divp_e;

endpackage

`default_nettype wire

>>> design/srws_ram.sv
// ----------------------------------------------------------------------------
// srws_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/srws_div.sv
// ----------------------------------------------------------------------------
// srws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srws_div
  import srws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DIV_BITS-1:0] dividend,
  input  wire logic [CNT_BITS-1:0] divisor,
  output      logic                busy,
  output      logic [DIV_BITS-1:0] quotient
);

  logic [CNT_BITS-1:0]      rem;
  logic [DIV_STEP_BITS-1:0] steps;
  logic [CNT_BITS:0]        rem_sh;
  logic                     ge;

  always_comb begin
    rem_sh = {rem, quotient[DIV_BITS-1]};
    ge     = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_STEP_BITS'(DIV_BITS);
    end else if (busy) begin
      steps <= steps - 1'b1;
      busy  <= steps != DIV_STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIV_BITS-2:0], ge};
      rem      <= ge ? CNT_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/srws_front.sv
// ----------------------------------------------------------------------------
// srws_front
// Accepts requests, tags them push or query, and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srws_front
  import srws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic                          operation,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic        [WIN_BITS-1:0]    window_length,
  output      item_t                         item,
  output      logic                          avail,
  input  wire logic                          take
);

  item_t                  fq [FQ_DEPTH];
  logic [FQ_PTR_BITS-1:0] wr_ptr;
  logic [FQ_PTR_BITS-1:0] rd_ptr;
  logic [FQ_CNT_BITS-1:0] count;
  logic                   acc;
  logic                   deq;
  item_t                  in_item;

  always_comb begin
    full          = count == FQ_CNT_BITS'(FQ_DEPTH);
    avail         = count != '0;
    acc           = push && !full;
    deq           = take && avail;
    in_item.op    = operation ? OP_QUERY : OP_PUSH;
    in_item.sample = sample;
    in_item.win   = window_length;
    item          = fq[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fq[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (acc) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FQ_CNT_BITS'(acc) - FQ_CNT_BITS'(deq);
    end
  end

  `CHK_ALWAYS(a_fq_bound, count <= FQ_CNT_BITS'(FQ_DEPTH), "request queue overfilled")

endmodule

`default_nettype wire

>>> design/srws_back.sv
// ----------------------------------------------------------------------------
// srws_back
// Statistics engine: writes pushed samples into the ring, walks the ring for
// queries and runs the shared divider and square root sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srws_back
  import srws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire item_t                         item,
  input  wire logic                          avail,
  output      logic                          take,
  input  wire logic                          pop,
  output      logic                          out_valid,
  output      logic signed [OUT_BITS-1:0]    recent_mean,
  output      logic signed [OUT_BITS-1:0]    overall_mean,
  output      logic        [OUT_BITS-1:0]    overall_deviation,
  output      logic        [WIN_BITS-1:0]    filled_count
);

  state_e state;
  state_e state_next;
  divp_e  phase;

  logic [ADDR_BITS-1:0] wp;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  j;
  logic [CNT_BITS-1:0]  win_n;
  logic                 rd_pend;
  logic                 rd_in_win;

  logic signed [SUM_BITS-1:0] sum_rec;
  logic signed [SUM_BITS-1:0] sum_all;
  logic        [SQ_BITS-1:0]  sq;
  logic        [D_BITS-1:0]   p1;
  logic        [D_BITS-1:0]   p2;
  logic        [D_BITS-1:0]   rad;
  logic        [D_BITS-1:0]   res;
  logic        [D_BITS-1:0]   bitm;

  logic signed [OUT_BITS-1:0] rec_q;
  logic signed [OUT_BITS-1:0] all_q;
  logic        [OUT_BITS-1:0] dev_q;

  logic                            we;
  logic [SAMPLE_BITS-1:0]          rdata;
  logic signed [SAMPLE_BITS-1:0]   x;
  logic signed [2*SAMPLE_BITS-1:0] xx;
  logic signed [2*SUM_BITS-1:0]    ssq;
  logic                            issue;
  logic [ADDR_BITS+1:0]            age_raw;
  logic [ADDR_BITS+1:0]            age;
  logic [CNT_BITS-1:0]             win_min;
  logic [D_BITS-1:0]               trial;

  logic                div_start;
  logic                div_busy;
  logic [DIV_BITS-1:0] div_dvd;
  logic [CNT_BITS-1:0] div_dsr;
  logic [DIV_BITS-1:0] div_quo;
  logic signed [SUM_BITS-1:0] div_src;
  logic signed [DIV_BITS:0]   signed_q;

  srws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (item.sample),
    .raddr (j[ADDR_BITS-1:0]),
    .rdata (rdata)
  );

  srws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_comb begin
    x   = $signed(rdata);
    xx  = x * x;
    ssq = sum_all * sum_all;
    win_min = (CNT_BITS'(item.win) < cnt) ? CNT_BITS'(item.win) : cnt;
    // age of sample j counted back from the newest one
    age_raw = (ADDR_BITS+2)'(wp) + (ADDR_BITS+2)'(DEPTH - 1) - (ADDR_BITS+2)'(j);
    age     = (age_raw >= (ADDR_BITS+2)'(DEPTH)) ?
              age_raw - (ADDR_BITS+2)'(DEPTH) : age_raw;
    issue   = (state == ST_WALK) && (j < cnt);
    trial   = res + bitm;
    take    = (state == ST_IDLE) && avail;
    we      = take && (item.op == OP_PUSH);

    unique case (phase)
      DP_RECENT: begin
        div_src = sum_rec;
        div_dsr = win_n;
      end
      DP_ALL: begin
        div_src = sum_all;
        div_dsr = cnt;
      end
      default: begin
        div_src = SUM_BITS'($signed({1'b0, res[ROOT_BITS-1:0]}));
        div_dsr = cnt;
      end
    endcase
    div_dvd  = (div_src < 0) ? DIV_BITS'(-div_src) : DIV_BITS'(div_src);
    signed_q = (div_src < 0) ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    div_start  = state == ST_DIV_GO;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (avail && item.op == OP_QUERY) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!issue && !rd_pend) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          unique case (phase)
            DP_RECENT: state_next = ST_DIV_GO;
            DP_ALL:    state_next = ST_MUL;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SQRT;
      ST_SQRT: begin
        if (bitm == '0) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DONE: begin
        if (!out_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      cnt       <= '0;
      j         <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      phase     <= DP_RECENT;
    end else begin
      rd_pend <= issue;
      if (we) begin
        wp <= (wp == ADDR_BITS'(DEPTH - 1)) ? '0 : wp + 1'b1;
        if (cnt != CNT_BITS'(DEPTH)) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (take && item.op == OP_QUERY) begin
        j     <= '0;
        phase <= DP_RECENT;
      end
      if (issue) begin
        j <= j + 1'b1;
      end
      if (state == ST_DIV_WAIT && !div_busy) begin
        unique case (phase)
          DP_RECENT: phase <= DP_ALL;
          DP_ALL:    phase <= DP_DEV;
          default:   phase <= DP_DEV;
        endcase
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end else if (state == ST_DONE && !out_valid) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.op == OP_QUERY) begin
      win_n   <= win_min;
      sum_rec <= '0;
      sum_all <= '0;
      sq      <= '0;
    end
    if (issue) begin
      rd_in_win <= age < (ADDR_BITS+2)'(win_n);
    end
    if (rd_pend) begin
      sum_all <= sum_all + SUM_BITS'(x);
      sq      <= sq + SQ_BITS'($unsigned(xx));
      if (rd_in_win) begin
        sum_rec <= sum_rec + SUM_BITS'(x);
      end
    end
    if (state == ST_DIV_WAIT && !div_busy) begin
      unique case (phase)
        DP_RECENT: rec_q <= (win_n == '0) ? '0 : OUT_BITS'(signed_q);
        DP_ALL:    all_q <= (cnt == '0) ? '0 : OUT_BITS'(signed_q);
        default: begin
          if (cnt <= CNT_BITS'(1)) begin
            dev_q <= '0;
          end else if (div_quo > DIV_BITS'({OUT_BITS{1'b1}})) begin
            dev_q <= '1;
          end else begin
            dev_q <= OUT_BITS'(div_quo);
          end
        end
      endcase
    end
    // n * sum of squares minus squared sum gives n^2 times the variance
    if (state == ST_MUL) begin
      p1 <= D_BITS'(cnt) * D_BITS'(sq);
      p2 <= D_BITS'($unsigned(ssq));
    end
    if (state == ST_DIFF) begin
      rad  <= p1 - p2;
      res  <= '0;
      bitm <= D_BITS'(1) << (D_BITS - 2);
    end
    if (state == ST_SQRT && bitm != '0) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
    if (state == ST_DONE && !out_valid) begin
      recent_mean       <= rec_q;
      overall_mean      <= all_q;
      overall_deviation <= dev_q;
      filled_count      <= WIN_BITS'(cnt);
    end
  end

  `CHK_ALWAYS(a_cnt_cap, cnt <= CNT_BITS'(DEPTH), "valid count above depth")
  `CHK_ALWAYS(a_walk_bound, j <= cnt, "walk index past valid count")
  `CHK_IMPLY(a_div_idle, div_start, !div_busy, "divider restarted while busy")
  `CHK_IMPLY(a_read_in_walk, rd_pend, state == ST_WALK, "store read outside walk")

endmodule

`default_nettype wire

>>> design/sample_ring_window_statistics.sv
// Push: accepted into the front queue while it is not full, then written to the ring
// when the engine takes it. Query: the time to a result is set by the ring walk (one
// sample read a cycle) and the shared one-bit-per-cycle divider and square root.
// Pushes retire at one per cycle while the engine is idle; a query blocks the engine
// until its result is loaded into the outputs, which waits for any earlier result's pop.
// rst clears pointers, count and queues; ring contents are not cleared.
// ----------------------------------------------------------------------------
// sample_ring_window_statistics
// Ring of recent samples with windowed mean, overall mean and deviation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_ring_window_statistics
  import srws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic                          operation,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic        [WIN_BITS-1:0]    window_length,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic signed [OUT_BITS-1:0]    recent_mean,
  output      logic signed [OUT_BITS-1:0]    overall_mean,
  output      logic        [OUT_BITS-1:0]    overall_deviation,
  output      logic        [WIN_BITS-1:0]    filled_count
);

  item_t item;
  logic  avail;
  logic  take;
  logic  out_valid;

  srws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .sample        (sample),
    .window_length (window_length),
    .item          (item),
    .avail         (avail),
    .take          (take)
  );

  srws_back u_back (
    .clk               (clk),
    .rst               (rst),
    .item              (item),
    .avail             (avail),
    .take              (take),
    .pop               (pop),
    .out_valid         (out_valid),
    .recent_mean       (recent_mean),
    .overall_mean      (overall_mean),
    .overall_deviation (overall_deviation),
    .filled_count      (filled_count)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire
